// File: design/cdq_pkg.sv
// Shared types and constants for the circular deque.
`default_nettype none

package cdq_pkg;

	localparam int CAP_CFG_W = 7;
	localparam int CAP_RESET = 64;
	localparam int STATUS_W  = 2;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_cmd_t;

endpackage

`default_nettype wire

// File: design/cdq_req_if.sv
// Request channel: opcode and push value.
`default_nettype none

interface cdq_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	cdq_pkg::opcode_t             opcode;
	logic signed [DATA_WIDTH-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

// File: design/cdq_rsp_if.sv
// Result channel: popped value, status and occupancy flags.
`default_nettype none

interface cdq_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] popped_value;
	cdq_pkg::status_t             status;
	logic                         now_empty;
	logic                         now_full;

	modport source (output valid, output popped_value, output status, output now_empty,
		output now_full, input ready);
	modport sink   (input valid, input popped_value, input status, input now_empty,
		input now_full, output ready);
endinterface

`default_nettype wire

// File: design/cdq_cfg_if.sv
// Configuration write channel carrying the capacity register.
`default_nettype none

interface cdq_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cdq_pkg::CAP_CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/cdq_store.sv
// Single-port slot store with registered read data.
`default_nettype none

module cdq_store #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire                          clk,
	input  cdq_pkg::mem_cmd_t            cmd,
	input  wire  [$clog2(DEPTH)-1:0]     addr,
	input  wire  [DATA_WIDTH-1:0]        wdata,
	output logic [DATA_WIDTH-1:0]        rdata
);
	import cdq_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[addr] <= wdata;
		end
		if (cmd.re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/cdq_ctrl.sv
// Index bookkeeping, store sequencing and result register for the deque.
`default_nettype none

module cdq_ctrl #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	cdq_cfg_if.sink                    cfg,
	cdq_req_if.sink                    req,
	cdq_rsp_if.source                  rsp,
	output cdq_pkg::mem_cmd_t          mem_cmd,
	output logic [$clog2(DEPTH)-1:0]   mem_addr,
	output logic [DATA_WIDTH-1:0]      mem_wdata,
	input  wire  [DATA_WIDTH-1:0]      mem_rdata
);
	import cdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CAP_W = IDX_W + 1;
	localparam int CMP_W = (CAP_W > CAP_CFG_W) ? CAP_W : CAP_CFG_W;
	localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	state_t state_q, state_n;

	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic             vacant_q;

	logic [IDX_W-1:0] head_n, tail_n;
	logic             vacant_n;

	logic [CAP_W-1:0] head_ext, tail_ext, head_p1, tail_p1;
	logic [CAP_W-1:0] head_inc, tail_inc, head_dec, tail_dec;
	logic [CAP_W-1:0] tail_n_p1, tail_n_inc;
	logic             full_now, full_next, pop_ok, accept;
	status_t          status_n;
	logic [CMP_W-1:0] cfg_ext;
	logic [CAP_W-1:0] cap_cfg;

	logic                  rsp_valid_q;
	logic [DATA_WIDTH-1:0] popped_q;
	status_t               status_q;
	logic                  empty_q, full_q;

	// wrap arithmetic against the live capacity
	always_comb begin
		head_ext = CAP_W'(head_q);
		tail_ext = CAP_W'(tail_q);
		head_p1  = head_ext + CAP_W'(1);
		tail_p1  = tail_ext + CAP_W'(1);
		head_inc = (head_p1 >= cap_q) ? '0 : head_p1;
		tail_inc = (tail_p1 >= cap_q) ? '0 : tail_p1;
		head_dec = (head_ext == '0 || head_ext >= cap_q) ? cap_q - CAP_W'(1)
			: head_ext - CAP_W'(1);
		tail_dec = (tail_ext == '0 || tail_ext >= cap_q) ? cap_q - CAP_W'(1)
			: tail_ext - CAP_W'(1);
		full_now = !vacant_q && (tail_inc == head_ext);
	end

	// state update for the request on the port
	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		vacant_n  = vacant_q;
		status_n  = STAT_DONE;
		pop_ok    = 1'b0;
		mem_addr  = head_q;
		mem_cmd   = '0;
		unique case (req.opcode)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full_now) begin
					status_n = STAT_FULL;
				end else if (vacant_q) begin
					head_n      = '0;
					tail_n      = '0;
					vacant_n    = 1'b0;
					mem_addr    = '0;
					mem_cmd.we  = accept;
				end else if (req.opcode == OP_PUSH_FRONT) begin
					head_n      = IDX_W'(head_dec);
					mem_addr    = IDX_W'(head_dec);
					mem_cmd.we  = accept;
				end else begin
					tail_n      = IDX_W'(tail_inc);
					mem_addr    = IDX_W'(tail_inc);
					mem_cmd.we  = accept;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (vacant_q) begin
					status_n = STAT_EMPTY;
				end else begin
					pop_ok     = 1'b1;
					mem_cmd.re = accept;
					mem_addr   = (req.opcode == OP_POP_FRONT) ? head_q : tail_q;
					if (head_q == tail_q) begin
						head_n   = '0;
						tail_n   = '0;
						vacant_n = 1'b1;
					end else if (req.opcode == OP_POP_FRONT) begin
						head_n = IDX_W'(head_inc);
					end else begin
						tail_n = IDX_W'(tail_dec);
					end
				end
			end
			default: begin
				status_n = STAT_DONE;
			end
		endcase
		tail_n_p1  = CAP_W'(tail_n) + CAP_W'(1);
		tail_n_inc = (tail_n_p1 >= cap_q) ? '0 : tail_n_p1;
		full_next  = !vacant_n && (tail_n_inc == CAP_W'(head_n));
	end

	assign mem_wdata = req.push_value;

	// capacity clamp: zero reads as one, above the store depth reads as the depth
	always_comb begin
		cfg_ext = CMP_W'(cfg.data);
		if (cfg_ext == '0) begin
			cap_cfg = CAP_W'(1);
		end else if (cfg_ext > DEPTH_C) begin
			cap_cfg = CAP_W'(DEPTH);
		end else begin
			cap_cfg = CAP_W'(cfg_ext);
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && pop_ok) begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// handshake outputs; a pop holds off the next request until its data lands
	always_comb begin
		req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
		cfg.ready = 1'b1;
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= CAP_W'(CAP_RST);
			head_q   <= '0;
			tail_q   <= '0;
			vacant_q <= 1'b1;
		end else begin
			state_q <= state_n;
			if (cfg.valid && cfg.ready) begin
				cap_q    <= cap_cfg;
				head_q   <= '0;
				tail_q   <= '0;
				vacant_q <= 1'b1;
			end else if (accept) begin
				head_q   <= head_n;
				tail_q   <= tail_n;
				vacant_q <= vacant_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= !pop_ok;
		end else if (state_q == S_READ) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= '0;
			status_q <= status_n;
			empty_q  <= vacant_n;
			full_q   <= full_next;
		end else if (state_q == S_READ) begin
			popped_q <= mem_rdata;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.now_empty    = empty_q;
	assign rsp.now_full     = full_q;

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !req.ready)
		else $error("request taken while a pop read is pending");

	a_read_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> rsp_valid_q)
		else $error("pop result not presented after store read");

	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_cmd.we && mem_cmd.re))
		else $error("store read and write in the same cycle");

	a_vacant_indices: assert property (@(posedge clk) disable iff (!arst_n)
		vacant_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty deque with nonzero indices");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CAP_W'(head_q) < cap_q) && (CAP_W'(tail_q) < cap_q))
		else $error("index beyond capacity");

endmodule

`default_nettype wire

// File: design/circular_deque.sv
// Top level of the circular deque.
`default_nettype none

// Double-ended queue over a single-port slot store of DEPTH entries, of which the
// first capacity slots are used. A push result is registered the cycle after the
// push is accepted; pushes and rejected requests sustain one per cycle while the
// result side is ready. A successful pop reads the store into its read register,
// then loads the result register; the next request is held off until it is loaded.
// Writing capacity empties the deque; the config channel is always ready and must
// only be used while no request is in flight.
module circular_deque #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	cdq_cfg_if.sink    cfg,
	cdq_req_if.sink    req,
	cdq_rsp_if.source  rsp
);
	import cdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	mem_cmd_t              mem_cmd;
	logic [IDX_W-1:0]      mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [DATA_WIDTH-1:0] mem_rdata;

	cdq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.mem_cmd   (mem_cmd),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	cdq_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// File: verif/circular_deque_tb.sv
// Self-checking testbench for circular_deque: directed and random deque traffic.
module circular_deque_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int SEG_ITEMS   = 30;

	typedef struct {
		logic [DATA_WIDTH-1:0] popped_value;
		status_t               status;
		logic                  now_empty;
		logic                  now_full;
	} deque_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cdq_cfg_if                            cfg_ch ();
	cdq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
	cdq_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

	circular_deque #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #2 clk = ~clk;

	// deque shadow state
	logic [DATA_WIDTH-1:0] slot_shadow [DEPTH];
	int                    front_slot;
	int                    rear_slot;
	logic                  shadow_vacant;
	logic [CAP_CFG_W-1:0]  capacity_reg;

	deque_result_t pending_results [$];
	int            error_count;
	int            stall_cycles;
	int            src_idle_pct;
	int            snk_idle_pct;
	int            hold_ask;
	int            hold_left;
	// -1 picks a random capacity
	int            cap_plan [12] = '{2, 5, 1, 3, 0, 7, 65, 16, 127, 4, -1, 3};

	function automatic int live_capacity();
		int c;
		c = capacity_reg;
		if (c < 1)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		return c;
	endfunction

	function automatic int slot_next(int idx, int c);
		return (idx + 1 >= c) ? 0 : idx + 1;
	endfunction

	function automatic int slot_prev(int idx, int c);
		return (idx == 0 || idx >= c) ? c - 1 : idx - 1;
	endfunction

	function automatic logic shadow_full(int c);
		return !shadow_vacant && slot_next(rear_slot, c) == front_slot;
	endfunction

	function automatic void clear_shadow();
		front_slot    = 0;
		rear_slot     = 0;
		shadow_vacant = 1'b1;
	endfunction

	function automatic deque_result_t deque_step(opcode_t op, logic [DATA_WIDTH-1:0] value);
		deque_result_t r;
		int c;
		c              = live_capacity();
		r.popped_value = '0;
		r.status       = STAT_DONE;
		if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
			if (shadow_full(c)) begin
				r.status = STAT_FULL;
			end else if (shadow_vacant) begin
				// first element always lands in slot 0
				front_slot     = 0;
				rear_slot      = 0;
				shadow_vacant  = 1'b0;
				slot_shadow[0] = value;
			end else if (op == OP_PUSH_FRONT) begin
				front_slot              = slot_prev(front_slot, c);
				slot_shadow[front_slot] = value;
			end else begin
				rear_slot              = slot_next(rear_slot, c);
				slot_shadow[rear_slot] = value;
			end
		end else if (shadow_vacant) begin
			r.status = STAT_EMPTY;
		end else begin
			r.popped_value = slot_shadow[(op == OP_POP_FRONT) ? front_slot : rear_slot];
			if (front_slot == rear_slot)
				clear_shadow();
			else if (op == OP_POP_FRONT)
				front_slot = slot_next(front_slot, c);
			else
				rear_slot = slot_prev(rear_slot, c);
		end
		r.now_empty = shadow_vacant;
		r.now_full  = shadow_full(c);
		return r;
	endfunction

	task automatic check_field(string name, logic [DATA_WIDTH-1:0] expv,
		logic [DATA_WIDTH-1:0] actv);
		if (expv !== actv) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
		end
	endtask

	// transfer monitor, predictor and scoreboard in one process
	always @(posedge clk) begin
		deque_result_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, status %0d value %h", $time,
						rsp_ch.status, rsp_ch.popped_value);
				end else begin
					want = pending_results.pop_front();
					check_field("popped_value", want.popped_value, rsp_ch.popped_value);
					check_field("status", want.status, rsp_ch.status);
					check_field("now_empty", want.now_empty, rsp_ch.now_empty);
					check_field("now_full", want.now_full, rsp_ch.now_full);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				moved        = 1'b1;
				capacity_reg = cfg_ch.data;
				clear_shadow();
			end
			if (req_ch.valid && req_ch.ready) begin
				moved = 1'b1;
				pending_results.push_back(deque_step(req_ch.opcode, req_ch.push_value));
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// result-side ready, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	function automatic logic [DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// starts just after a rising edge, returns at the edge where the transfer happens
	task automatic send_req(opcode_t op, logic [DATA_WIDTH-1:0] value);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.push_value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_CFG_W-1:0] value);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// push-heavy first half, pop-heavy second half, so both full and empty are hit
	task automatic run_segment(int count);
		opcode_t op;
		int push_pct;
		for (int i = 0; i < count; i++) begin
			push_pct = (i < count / 2) ? 70 : 30;
			if ($urandom_range(0, 99) < push_pct)
				op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
			send_req(op, pick_value());
		end
	endtask

	task automatic test_directed();
		// reset capacity, both pops on an empty deque, extremes of the value
		send_req(OP_POP_FRONT, pick_value());
		send_req(OP_POP_REAR, pick_value());
		send_req(OP_PUSH_FRONT, 32'h8000_0000);
		send_req(OP_PUSH_REAR, 32'h7fff_ffff);
		send_req(OP_PUSH_FRONT, 32'hffff_ffff);
		send_req(OP_PUSH_REAR, 32'h0000_0000);
		send_req(OP_POP_REAR, pick_value());
		send_req(OP_POP_FRONT, pick_value());
		send_req(OP_POP_FRONT, pick_value());
		send_req(OP_POP_REAR, pick_value());
		// single slot: full after one push
		write_capacity(7'd1);
		send_req(OP_PUSH_REAR, 32'h1234_5678);
		send_req(OP_PUSH_FRONT, 32'hdead_beef);
		send_req(OP_POP_FRONT, pick_value());
		send_req(OP_POP_REAR, pick_value());
		// zero clamps to one; leave an element behind for the next write to discard
		write_capacity(7'd0);
		send_req(OP_PUSH_FRONT, 32'h0000_0005);
		send_req(OP_PUSH_REAR, 32'h0000_0006);
		write_capacity(7'd2);
		send_req(OP_POP_FRONT, pick_value());
		send_req(OP_PUSH_FRONT, 32'haaaa_5555);
		send_req(OP_PUSH_FRONT, 32'h5555_aaaa);
		send_req(OP_PUSH_REAR, 32'h0f0f_0f0f);
		send_req(OP_POP_FRONT, pick_value());
		send_req(OP_POP_REAR, pick_value());
	endtask

	task automatic test_random(int phase, int src_pct, int snk_pct);
		int c;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int k = 0; k < 4; k++) begin
			c = cap_plan[phase * 4 + k];
			if (c < 0)
				c = $urandom_range(1, DEPTH);
			write_capacity(c[CAP_CFG_W-1:0]);
			run_segment(SEG_ITEMS);
		end
	endtask

	// whole store in use, wrap through every slot, reject at both ends
	task automatic test_fill_to_capacity();
		write_capacity(7'd64);
		for (int i = 0; i < DEPTH + 2; i++)
			send_req($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
		for (int i = 0; i < DEPTH + 2; i++)
			send_req($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, pick_value());
	endtask

	// result side blocked for a long time while requests keep coming
	task automatic test_output_stall();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_capacity(7'd8);
		hold_ask = 300;
		run_segment(40);
		wait_drained();
	endtask

	initial begin
		error_count       = 0;
		stall_cycles      = 0;
		hold_ask          = 0;
		hold_left         = 0;
		src_idle_pct      = 10;
		snk_idle_pct      = 48;
		capacity_reg      = CAP_RESET;
		clear_shadow();
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_PUSH_FRONT;
		req_ch.push_value = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		rsp_ch.ready      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(0, 10, 48);
		test_random(1, 48, 10);
		test_random(2, 0, 0);
		test_fill_to_capacity();
		test_output_stall();

		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: circular_deque.f
design/cdq_pkg.sv
design/cdq_req_if.sv
design/cdq_rsp_if.sv
design/cdq_cfg_if.sv
design/cdq_store.sv
design/cdq_ctrl.sv
design/circular_deque.sv
verif/circular_deque_tb.sv
